// ===== rtl/alfl_pkg.sv =====
package alfl_pkg;

  // default table depth
  localparam int NODES_DEF = 16;

  // request codes
  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_NO_NEXT = 2'd2
  } status_t;

  // memory port controls, per cycle
  typedef struct packed {
    logic rd;
    logic link_we;
    logic value_we;
  } mem_ctl_t;

endpackage

// ===== rtl/alfl_store.sv =====
module alfl_store #(
  parameter int NODES = alfl_pkg::NODES_DEF,
  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1,
  localparam int LW = IW + 1
) (
  input  logic               clk,
  input  alfl_pkg::mem_ctl_t ctl,
  input  logic [IW-1:0]      link_ra,
  input  logic [IW-1:0]      link_rb,
  input  logic [IW-1:0]      value_ra,
  input  logic [IW-1:0]      link_wa,
  input  logic [LW-1:0]      link_wd,
  input  logic [IW-1:0]      value_wa,
  input  logic [31:0]        value_wd,
  output logic [LW-1:0]      link_qa,
  output logic [LW-1:0]      link_qb,
  output logic [31:0]        value_q
);

  // link entry: {null flag, next index}
  logic [LW-1:0] link_mem [NODES];
  logic [31:0]   value_mem [NODES];

  // link table: two read ports, one write port
  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (ctl.rd) begin
      link_qa <= link_mem[link_ra];
      link_qb <= link_mem[link_rb];
    end
  end

  // value table: one read port, one write port
  always_ff @(posedge clk) begin
    if (ctl.value_we) begin
      value_mem[value_wa] <= value_wd;
    end
    if (ctl.rd) begin
      value_q <= value_mem[value_ra];
    end
  end

endmodule

// ===== rtl/array_linked_list_with_free_list.sv =====
// Linked list in a node table, with a free list, one request at a time.
// done pulses from S_EXEC for create, read and failed requests; insert goes on
// through S_WR2, and delete through S_DEL_RD and then S_WR2, before done.
// A new request is taken only in S_IDLE, once the last one is through and busy is low.
// Reset: a clearing pass through S_CLEAR rebuilds the free chain; busy is high meanwhile.
// The receiver cannot stall: each result is shown for the single cycle done is high.
module array_linked_list_with_free_list #(
  parameter int NODES = alfl_pkg::NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [3:0]  node_index,
  input  logic [31:0] item_value,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  result_node,
  output logic [31:0] entry_value,
  output logic [3:0]  entry_next,
  output logic        next_is_null
);

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = IW + 1;
  localparam int RW = (IW + 1 > 5) ? IW + 1 : 5;
  localparam logic [IW-1:0] LAST = IW'(NODES - 1);
  localparam logic [LW-1:0] NULL_LINK = {1'b1, {IW{1'b0}}};

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_DEL_RD = 5'b01000,
    S_WR2    = 5'b10000
  } state_t;

  state_t                state;
  logic [IW-1:0]         clr;
  logic [LW-1:0]         fh;
  alfl_pkg::mode_t       mode_q;
  logic [IW-1:0]         r_q;
  logic [31:0]           v_q;
  logic [IW-1:0]         q_q;
  logic [IW-1:0]         wa2;
  logic [LW-1:0]         wd2;

  alfl_pkg::mem_ctl_t    ctl;
  logic [IW-1:0]         link_ra;
  logic [IW-1:0]         link_rb;
  logic [IW-1:0]         value_ra;
  logic [IW-1:0]         link_wa;
  logic [LW-1:0]         link_wd;
  logic [IW-1:0]         value_wa;
  logic [31:0]           value_wd;
  logic [LW-1:0]         link_qa;
  logic [LW-1:0]         link_qb;
  logic [31:0]           value_q;

  logic [RW-1:0]         red;
  logic [IW-1:0]         r_in;

  assign busy = (state != S_IDLE);

  // node_index modulo NODES: at most seven subtractions on a 4-bit value
  always_comb begin
    red = RW'(node_index);
    for (int k = 0; k < 8; k++) begin
      if (red >= RW'(NODES)) begin
        red = red - RW'(NODES);
      end
    end
    r_in = red[IW-1:0];
  end

  alfl_store #(.NODES(NODES)) u_store (
    .clk      (clk),
    .ctl      (ctl),
    .link_ra  (link_ra),
    .link_rb  (link_rb),
    .value_ra (value_ra),
    .link_wa  (link_wa),
    .link_wd  (link_wd),
    .value_wa (value_wa),
    .value_wd (value_wd),
    .link_qa  (link_qa),
    .link_qb  (link_qb),
    .value_q  (value_q)
  );

  // memory addressing per state
  always_comb begin
    ctl      = '0;
    link_ra  = fh[IW-1:0];
    link_rb  = r_in;
    value_ra = r_in;
    link_wa  = clr;
    link_wd  = NULL_LINK;
    value_wa = fh[IW-1:0];
    value_wd = v_q;
    unique case (state)
      S_CLEAR: begin
        ctl.link_we = 1'b1;
        link_wa     = clr;
        link_wd     = (clr == LAST) ? NULL_LINK : {1'b0, clr + IW'(1)};
      end
      S_IDLE: begin
        // fetch free head link, link and value of the named node
        ctl.rd = start;
      end
      S_EXEC: begin
        case (mode_q)
          alfl_pkg::MODE_CREATE: begin
            if (!fh[IW]) begin
              ctl.link_we  = 1'b1;
              ctl.value_we = 1'b1;
              link_wa      = fh[IW-1:0];
              link_wd      = NULL_LINK;
            end
          end
          alfl_pkg::MODE_INSERT: begin
            // new node takes over the successor of the named node
            if (!fh[IW]) begin
              ctl.link_we  = 1'b1;
              ctl.value_we = 1'b1;
              link_wa      = fh[IW-1:0];
              link_wd      = link_qb;
            end
          end
          alfl_pkg::MODE_DELETE: begin
            // fetch the node being unlinked
            if (!link_qb[IW]) begin
              ctl.rd   = 1'b1;
              link_ra  = link_qb[IW-1:0];
              value_ra = link_qb[IW-1:0];
            end
          end
          alfl_pkg::MODE_READ: begin
          end
        endcase
      end
      S_DEL_RD: begin
        // named node skips over the removed one
        ctl.link_we = 1'b1;
        link_wa     = r_q;
        link_wd     = link_qa;
      end
      S_WR2: begin
        ctl.link_we = 1'b1;
        link_wa     = wa2;
        link_wd     = wd2;
      end
      default: begin
      end
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      fh    <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + IW'(1);
          if (clr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            mode_q <= alfl_pkg::mode_t'(mode);
            r_q    <= r_in;
            v_q    <= item_value;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (mode_q)
            alfl_pkg::MODE_CREATE: begin
              done  <= 1'b1;
              state <= S_IDLE;
              if (fh[IW]) begin
                status       <= alfl_pkg::ST_NO_FREE;
                result_node  <= '0;
                entry_value  <= '0;
                entry_next   <= '0;
                next_is_null <= 1'b0;
              end else begin
                fh           <= link_qa;
                status       <= alfl_pkg::ST_OK;
                result_node  <= 4'(fh[IW-1:0]);
                entry_value  <= v_q;
                entry_next   <= '0;
                next_is_null <= 1'b1;
              end
            end
            alfl_pkg::MODE_INSERT: begin
              if (fh[IW]) begin
                done         <= 1'b1;
                state        <= S_IDLE;
                status       <= alfl_pkg::ST_NO_FREE;
                result_node  <= '0;
                entry_value  <= '0;
                entry_next   <= '0;
                next_is_null <= 1'b0;
              end else begin
                fh           <= link_qa;
                wa2          <= r_q;
                wd2          <= {1'b0, fh[IW-1:0]};
                status       <= alfl_pkg::ST_OK;
                result_node  <= 4'(fh[IW-1:0]);
                entry_value  <= v_q;
                if (r_q == fh[IW-1:0]) begin
                  // named node is the one taken: it ends up linked to itself
                  entry_next   <= 4'(fh[IW-1:0]);
                  next_is_null <= 1'b0;
                end else begin
                  entry_next   <= link_qb[IW] ? 4'd0 : 4'(link_qb[IW-1:0]);
                  next_is_null <= link_qb[IW];
                end
                state        <= S_WR2;
              end
            end
            alfl_pkg::MODE_DELETE: begin
              if (link_qb[IW]) begin
                done         <= 1'b1;
                state        <= S_IDLE;
                status       <= alfl_pkg::ST_NO_NEXT;
                result_node  <= '0;
                entry_value  <= '0;
                entry_next   <= '0;
                next_is_null <= 1'b0;
              end else begin
                q_q   <= link_qb[IW-1:0];
                state <= S_DEL_RD;
              end
            end
            alfl_pkg::MODE_READ: begin
              done         <= 1'b1;
              state        <= S_IDLE;
              status       <= alfl_pkg::ST_OK;
              result_node  <= 4'(r_q);
              entry_value  <= value_q;
              entry_next   <= link_qb[IW] ? 4'd0 : 4'(link_qb[IW-1:0]);
              next_is_null <= link_qb[IW];
            end
          endcase
        end
        S_DEL_RD: begin
          // removed node goes on top of the free list
          wa2          <= q_q;
          wd2          <= fh;
          fh           <= {1'b0, q_q};
          status       <= alfl_pkg::ST_OK;
          result_node  <= 4'(q_q);
          entry_value  <= value_q;
          entry_next   <= fh[IW] ? 4'd0 : 4'(fh[IW-1:0]);
          next_is_null <= fh[IW];
          state        <= S_WR2;
        end
        S_WR2: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/array_linked_list_with_free_list_tb.sv =====
module array_linked_list_with_free_list_tb;

  localparam int TABLE_SIZE   = alfl_pkg::NODES_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int BIAS_BLOCK   = 50;

  // one expected result of a list request
  typedef struct {
    alfl_pkg::status_t status;
    logic [3:0]        node;
    logic [31:0]       value;
    logic [3:0]        link;
    logic              is_null;
  } node_report_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [3:0]  node_index;
  logic [31:0] item_value;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  result_node;
  logic [31:0] entry_value;
  logic [3:0]  entry_next;
  logic        next_is_null;

  // shadow node table and free list
  logic [31:0] value_mem [TABLE_SIZE];
  bit   [3:0]  link_mem [TABLE_SIZE];
  bit          link_null_mem [TABLE_SIZE];
  bit   [3:0]  free_top;
  bit          free_empty;
  bit          written [TABLE_SIZE];
  bit          allocated [TABLE_SIZE];

  node_report_t pending_reports[$];
  int errors;
  int cycle_count;
  int n_ok, n_no_free, n_no_next;

  array_linked_list_with_free_list dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .node_index  (node_index),
    .item_value  (item_value),
    .done        (done),
    .status      (status),
    .result_node (result_node),
    .entry_value (entry_value),
    .entry_next  (entry_next),
    .next_is_null(next_is_null)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // apply one request to the shadow table, return what the block must report
  function automatic node_report_t apply_request(alfl_pkg::mode_t m, logic [3:0] idx,
                                                 logic [31:0] v);
    node_report_t rep;
    logic [3:0] q;
    rep.status  = alfl_pkg::ST_OK;
    rep.node    = '0;
    rep.value   = '0;
    rep.link    = '0;
    rep.is_null = 1'b0;
    case (m)
      alfl_pkg::MODE_CREATE, alfl_pkg::MODE_INSERT: begin
        if (free_empty) begin
          rep.status = alfl_pkg::ST_NO_FREE;
        end else begin
          q = free_top;
          free_top = link_mem[q];
          free_empty = link_null_mem[q];
          value_mem[q] = v;
          written[q] = 1'b1;
          allocated[q] = 1'b1;
          if (m == alfl_pkg::MODE_CREATE) begin
            link_mem[q] = '0;
            link_null_mem[q] = 1'b1;
          end else begin
            link_mem[q] = link_mem[idx];
            link_null_mem[q] = link_null_mem[idx];
            link_mem[idx] = q;
            link_null_mem[idx] = 1'b0;
          end
          rep.node    = q;
          rep.value   = v;
          rep.is_null = link_null_mem[q];
          rep.link    = link_null_mem[q] ? 4'd0 : link_mem[q];
        end
      end
      alfl_pkg::MODE_DELETE: begin
        if (link_null_mem[idx]) begin
          rep.status = alfl_pkg::ST_NO_NEXT;
        end else begin
          q = link_mem[idx];
          link_mem[idx] = link_mem[q];
          link_null_mem[idx] = link_null_mem[q];
          link_mem[q] = free_top;
          link_null_mem[q] = free_empty;
          free_top = q;
          free_empty = 1'b0;
          allocated[q] = 1'b0;
          rep.node    = q;
          rep.value   = value_mem[q];
          rep.is_null = link_null_mem[q];
          rep.link    = link_null_mem[q] ? 4'd0 : link_mem[q];
        end
      end
      default: begin
        rep.node    = idx;
        rep.value   = value_mem[idx];
        rep.is_null = link_null_mem[idx];
        rep.link    = link_null_mem[idx] ? 4'd0 : link_mem[idx];
      end
    endcase
    return rep;
  endfunction

  // send one item, idling first at the given percentage per cycle
  task automatic send_request(alfl_pkg::mode_t m, logic [3:0] idx, logic [31:0] v,
                              int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= m;
    node_index <= idx;
    item_value <= v;
    do @(posedge clk); while (busy);
    pending_reports.push_back(apply_request(m, idx, v));
  endtask

  // check each result against the oldest expectation
  always @(posedge clk) begin : check_results
    node_report_t want;
    if (!rst && done) begin
      if (pending_reports.size() == 0) begin
        $error("result with no request outstanding: node %0d", result_node);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        case (want.status)
          alfl_pkg::ST_OK:      n_ok++;
          alfl_pkg::ST_NO_FREE: n_no_free++;
          default:              n_no_next++;
        endcase
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (result_node !== want.node) begin
          $error("result_node: expected %0d, got %0d", want.node, result_node);
          errors++;
        end
        if (entry_value !== want.value) begin
          $error("entry_value: expected %0h, got %0h", want.value, entry_value);
          errors++;
        end
        if (entry_next !== want.link) begin
          $error("entry_next: expected %0d, got %0d", want.link, entry_next);
          errors++;
        end
        if (next_is_null !== want.is_null) begin
          $error("next_is_null: expected %0d, got %0d", want.is_null, next_is_null);
          errors++;
        end
      end
    end
  end

  // build one chain through all nodes but the last, create the last one alone, then run out of nodes
  task automatic test_fill_table();
    logic [31:0] patterns [14] = '{
      32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555,
      32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0001, 32'h1234_5678,
      32'hFEDC_BA98, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_FFFE,
      32'h8000_0000, 32'hDEAD_BEEF
    };
    send_request(alfl_pkg::MODE_CREATE, 4'd0, 32'h8000_0000, 0);
    for (int i = 0; i < 14; i++) begin
      send_request(alfl_pkg::MODE_INSERT, 4'(i), patterns[i], 0);
    end
    send_request(alfl_pkg::MODE_CREATE, 4'd15, 32'h7FFF_FFFF, 0);
    // free list empty now
    send_request(alfl_pkg::MODE_CREATE, 4'd3, 32'h1111_1111, 0);
    send_request(alfl_pkg::MODE_INSERT, 4'd15, 32'h2222_2222, 0);
  endtask

  // reads, deletes with and without a successor, node reuse
  task automatic test_read_delete();
    send_request(alfl_pkg::MODE_READ, 4'd15, 32'h0, 0);
    send_request(alfl_pkg::MODE_READ, 4'd0, 32'hFFFF_FFFF, 0);
    send_request(alfl_pkg::MODE_DELETE, 4'd15, 32'h0, 0);
    send_request(alfl_pkg::MODE_DELETE, 4'd0, 32'h0, 0);
    send_request(alfl_pkg::MODE_DELETE, 4'd0, 32'h0, 0);
    send_request(alfl_pkg::MODE_READ, 4'd2, 32'h0, 0);
    send_request(alfl_pkg::MODE_INSERT, 4'd15, 32'hCAFE_F00D, 0);
    send_request(alfl_pkg::MODE_CREATE, 4'd0, 32'h8000_0000, 0);
    send_request(alfl_pkg::MODE_DELETE, 4'd14, 32'h0, 0);
  endtask

  // random traffic, alternating blocks that favor filling and draining
  task automatic test_random_traffic(int count, int idle_pct);
    int cand[$];
    alfl_pkg::mode_t m;
    logic [3:0] idx;
    logic [31:0] v;
    int roll;
    bit fill;
    for (int n = 0; n < count; n++) begin
      fill = ((n / BIAS_BLOCK) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 8) m = alfl_pkg::MODE_CREATE;
      else if (roll < (fill ? 63 : 23)) m = alfl_pkg::MODE_INSERT;
      else if (roll < 78) m = alfl_pkg::MODE_DELETE;
      else m = alfl_pkg::MODE_READ;
      // mostly name nodes that are on a list
      cand.delete();
      foreach (allocated[i]) if (allocated[i]) cand.push_back(i);
      if (cand.size() > 0 && $urandom_range(99) < 85)
        idx = 4'(cand[$urandom_range(cand.size() - 1)]);
      else idx = 4'($urandom_range(TABLE_SIZE - 1));
      // never touch a value that was never stored
      if ((m == alfl_pkg::MODE_READ && !written[idx]) ||
          (m == alfl_pkg::MODE_DELETE && !link_null_mem[idx] && !written[link_mem[idx]])) begin
        m = alfl_pkg::MODE_INSERT;
      end
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end else begin
        v = $urandom;
      end
      send_request(m, idx, v, idle_pct);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    mode       <= '0;
    node_index <= '0;
    item_value <= '0;
    // shadow state after reset: every node chained on the free list
    for (int i = 0; i < TABLE_SIZE; i++) begin
      value_mem[i]     = '0;
      link_mem[i]      = (i + 1 < TABLE_SIZE) ? 4'(i + 1) : 4'd0;
      link_null_mem[i] = (i + 1 >= TABLE_SIZE);
      written[i]       = 1'b0;
      allocated[i]     = 1'b0;
    end
    free_top   = '0;
    free_empty = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_fill_table();
    test_read_delete();
    test_random_traffic(600, 0);
    test_random_traffic(600, 74);
    test_random_traffic(600, 9);

    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d results: %0d ok, %0d out of nodes, %0d with nothing to delete",
             n_ok + n_no_free + n_no_next, n_ok, n_no_free, n_no_next);
    $display("Sender idle phases at 0, 74 and 9 percent; %0d mismatches", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
